/* sv/lnh_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Letter n-gram histogram package
// Field widths, command codes, letter range and the command and status
// bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package lnh_pkg;

    localparam int LETTER_BITS = 5;
    localparam int MODE_BITS   = 2;
    localparam int BYTE_BITS   = 8;
    localparam int INDEX_BITS  = 15;
    localparam int GLEN_BITS   = 2;
    localparam int OUT_BITS    = 32;

    // Command codes carried by the mode field.
    localparam logic [MODE_BITS-1:0] MODE_FEED  = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_READ  = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_CLEAR = 2'd2;

    localparam logic [BYTE_BITS-1:0] LETTER_FIRST = 8'h61;
    localparam logic [BYTE_BITS-1:0] LETTER_LAST  = 8'h7a;

    localparam logic [GLEN_BITS-1:0] GLEN_RESET = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;    // take the beat on the input channel
        logic mem_rd;    // read the counter at the latched address
        logic mem_wr;    // write back the incremented counter
        logic clr_en;    // zero one counter of the clearing pass
        logic load_out;  // move the read counter into the output register
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_hit;    // offered beat is a letter that completes a gram
        logic in_read;   // offered beat is a counter read
        logic in_clear;  // offered beat starts a new text
        logic cur_read;  // latched beat is a counter read
        logic clr_last;  // clearing pass is at its last counter
        logic out_free;  // output register can take a new beat
    } status_t;

endpackage

/* sv/lnh_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Letter n-gram histogram controller
// Sequences the clearing pass, the counter read-modify-write and the
// counter read-back, one input beat at a time.
// ----------------------------------------------------------------------------
module lnh_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  lnh_pkg::status_t status,
    output lnh_pkg::cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_WRITE,
        ST_RESULT
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clr_en = 1'b1;
                if (status.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                cmd.accept = s_valid;
                if (s_valid) begin
                    priority if (status.in_hit) begin
                        state_next = ST_READ;
                    end else if (status.in_read) begin
                        state_next = ST_READ;
                    end else if (status.in_clear) begin
                        state_next = ST_CLEAR;
                    end else begin
                        // Bytes that complete no gram and mode 3 finish here.
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_READ: begin
                cmd.mem_rd = 1'b1;
                state_next = status.cur_read ? ST_RESULT : ST_WRITE;
            end
            ST_WRITE: begin
                cmd.mem_wr = 1'b1;
                state_next = ST_IDLE;
            end
            ST_RESULT: begin
                // Hold the counter until the output register has room.
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

/* sv/lnh_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Letter n-gram histogram datapath
// Letter window, run length, gram length register, counter memory with its
// clearing sweep, saturating increment and the output register.
// ----------------------------------------------------------------------------
module lnh_datapath #(
    parameter int MAX_GRAM   = 3,
    parameter int COUNT_BITS = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  lnh_pkg::cmd_t                   cmd,
    output lnh_pkg::status_t                status,
    input  logic [lnh_pkg::MODE_BITS-1:0]   s_mode,
    input  logic [lnh_pkg::BYTE_BITS-1:0]   s_text_byte,
    input  logic [lnh_pkg::INDEX_BITS-1:0]  s_gram_index,
    input  logic                            cfg_wr_en,
    input  logic [lnh_pkg::GLEN_BITS-1:0]   cfg_wr_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [lnh_pkg::OUT_BITS-1:0]    m_gram_count
);

    localparam int WIN_BITS = lnh_pkg::LETTER_BITS * MAX_GRAM;
    localparam int DEPTH    = 1 << WIN_BITS;
    localparam int RUN_BITS = $clog2(MAX_GRAM + 1);
    localparam int LEN_BITS = (RUN_BITS > lnh_pkg::GLEN_BITS) ? RUN_BITS : lnh_pkg::GLEN_BITS;
    localparam logic [RUN_BITS-1:0] RUN_MAX = RUN_BITS'(MAX_GRAM);
    localparam logic [LEN_BITS-1:0] LEN_MAX = LEN_BITS'(MAX_GRAM);

    logic [COUNT_BITS-1:0]              count_mem [DEPTH];

    logic [WIN_BITS-1:0]                window_reg;
    logic [RUN_BITS-1:0]                run_reg;
    logic [lnh_pkg::GLEN_BITS-1:0]      glen_reg;
    logic [WIN_BITS-1:0]                clr_cnt_reg;
    logic [WIN_BITS-1:0]                addr_reg;
    logic                               cur_read_reg;
    logic [COUNT_BITS-1:0]              rdata_reg;
    logic                               out_valid_reg;
    logic [lnh_pkg::OUT_BITS-1:0]       out_count_reg;

    logic                               is_letter;
    logic [lnh_pkg::LETTER_BITS-1:0]    letter_code;
    logic [WIN_BITS+lnh_pkg::LETTER_BITS-1:0] shifted;
    logic [WIN_BITS-1:0]                window_next;
    logic [RUN_BITS-1:0]                run_next;
    logic [LEN_BITS-1:0]                len_eff;
    logic [LEN_BITS-1:0]                run_ext;
    logic [WIN_BITS-1:0]                feed_addr;
    logic [WIN_BITS+lnh_pkg::INDEX_BITS-1:0] index_wide;
    logic [WIN_BITS-1:0]                read_addr;
    logic [COUNT_BITS-1:0]              count_inc;
    logic [WIN_BITS-1:0]                wr_addr;
    logic [COUNT_BITS+lnh_pkg::OUT_BITS-1:0] count_wide;

    // Window shift and run length as they stand after the offered byte.
    always_comb begin
        is_letter   = (s_text_byte >= lnh_pkg::LETTER_FIRST)
                   && (s_text_byte <= lnh_pkg::LETTER_LAST);
        letter_code = lnh_pkg::LETTER_BITS'(s_text_byte - lnh_pkg::LETTER_FIRST);
        shifted     = {window_reg, letter_code};
        window_next = shifted[WIN_BITS-1:0];
        if (!is_letter) begin
            run_next = '0;
        end else if (run_reg == RUN_MAX) begin
            run_next = run_reg;
        end else begin
            run_next = run_reg + 1'b1;
        end
        len_eff = (LEN_BITS'(glen_reg) > LEN_MAX) ? LEN_MAX : LEN_BITS'(glen_reg);
        run_ext = LEN_BITS'(run_next);
        // Keep only the newest letters of the gram; older slots read as zero.
        for (int g = 0; g < MAX_GRAM; g++) begin
            feed_addr[g*lnh_pkg::LETTER_BITS +: lnh_pkg::LETTER_BITS] =
                (LEN_BITS'(g) < len_eff)
                    ? window_next[g*lnh_pkg::LETTER_BITS +: lnh_pkg::LETTER_BITS]
                    : '0;
        end
        index_wide = {{WIN_BITS{1'b0}}, s_gram_index};
        read_addr  = index_wide[WIN_BITS-1:0];
    end

    assign count_inc  = (rdata_reg == '1) ? rdata_reg : rdata_reg + 1'b1;
    assign wr_addr    = cmd.clr_en ? clr_cnt_reg : addr_reg;
    assign count_wide = {{lnh_pkg::OUT_BITS{1'b0}}, rdata_reg};

    assign status.in_hit   = (s_mode == lnh_pkg::MODE_FEED) && is_letter
                          && (len_eff != '0) && (run_ext >= len_eff);
    assign status.in_read  = (s_mode == lnh_pkg::MODE_READ);
    assign status.in_clear = (s_mode == lnh_pkg::MODE_CLEAR);
    assign status.cur_read = cur_read_reg;
    assign status.clr_last = (clr_cnt_reg == '1);
    assign status.out_free = !out_valid_reg || m_ready;

    assign m_valid      = out_valid_reg;
    assign m_gram_count = out_count_reg;

    // Counter memory: one write port shared by the sweep and the update.
    always_ff @(posedge aclk) begin
        if (cmd.clr_en || cmd.mem_wr) begin
            count_mem[wr_addr] <= cmd.clr_en ? '0 : count_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.mem_rd) begin
            rdata_reg <= count_mem[addr_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            addr_reg     <= status.in_read ? read_addr : feed_addr;
            cur_read_reg <= status.in_read;
        end
        if (cmd.load_out) begin
            out_count_reg <= count_wide[lnh_pkg::OUT_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg    <= '0;
            run_reg       <= '0;
            glen_reg      <= lnh_pkg::GLEN_RESET;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                glen_reg <= cfg_wr_data;
            end
            if (cmd.accept && status.in_clear) begin
                window_reg  <= '0;
                run_reg     <= '0;
                clr_cnt_reg <= '0;
            end else begin
                if (cmd.accept && (s_mode == lnh_pkg::MODE_FEED)) begin
                    if (is_letter) begin
                        window_reg <= window_next;
                    end
                    run_reg <= run_next;
                end
                if (cmd.clr_en) begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                end
            end
            if (cmd.load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

/* sv/letter_ngram_histogram_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Letter n-gram histogram core
// Counts n-grams of lowercase letters in a byte stream and reads counters back.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (s_valid/s_ready) carries one command per beat: mode 0
//   feeds s_text_byte, mode 1 reads the counter at s_gram_index, mode 2 clears
//   all counters and the letter window, mode 3 does nothing. Only mode 1
//   produces a beat on the result channel (m_valid/m_ready, m_gram_count).
//   gram_length is written through cfg_wr_en/cfg_wr_data; the user must do this
//   only while the core idles, as the core itself does not enforce it.
// Sequence:
//   A byte that completes a gram passes accept, counter read and counter write
//   back; any other byte and mode 3 end at accept. A read passes accept,
//   counter read and a result step that loads the output register and sets
//   m_valid once it has room. Each gram costs one counter read-modify-write.
// Reset and clear:
//   After reset, and after each clear command, the core sweeps the counter
//   memory writing zeros, one counter per cycle, over all 2**(5*MAX_GRAM)
//   counters, 32768 at the default. s_ready stays low during the sweep;
//   configuration writes are still taken.
// Back-pressure:
//   A result waits in the output register while m_ready is low, and the core
//   keeps taking beats; a second read stalls only when its counter is ready
//   and the output register is still full.
// ----------------------------------------------------------------------------
module letter_ngram_histogram_core #(
    parameter int MAX_GRAM   = 3,
    parameter int COUNT_BITS = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Input beats.
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [lnh_pkg::MODE_BITS-1:0]   s_mode,
    input  logic [lnh_pkg::BYTE_BITS-1:0]   s_text_byte,
    input  logic [lnh_pkg::INDEX_BITS-1:0]  s_gram_index,
    // Result beats.
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [lnh_pkg::OUT_BITS-1:0]    m_gram_count,
    // Gram length register.
    input  logic                            cfg_wr_en,
    input  logic [lnh_pkg::GLEN_BITS-1:0]   cfg_wr_data
);

    lnh_pkg::cmd_t    cmd;
    lnh_pkg::status_t status;

    // The controller only sequences; all state of the text lives in the datapath.
    lnh_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    lnh_datapath #(
        .MAX_GRAM   (MAX_GRAM),
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .status       (status),
        .s_mode       (s_mode),
        .s_text_byte  (s_text_byte),
        .s_gram_index (s_gram_index),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_gram_count (m_gram_count)
    );

    // The clearing sweep must keep the input channel closed.
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clr_en |-> !s_ready)
        else $error("input ready during clearing sweep");

    // A write back always follows the read of the same counter.
    a_write_after_read: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.mem_wr |-> $past(cmd.mem_rd))
        else $error("counter written back without a preceding read");

    // A result must never overwrite one that has not been taken.
    a_no_result_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_valid || m_ready))
        else $error("output register overwritten while stalled");

    // The sweep and the update share the write port and never collide.
    a_one_writer: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.mem_wr && cmd.clr_en))
        else $error("clearing sweep and counter update in the same cycle");

endmodule

/* sim/letter_ngram_histogram_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Letter n-gram histogram core testbench
// Sends feed, read, clear and no-op beats through the input channel and keeps
// its own copy of the counter array, letter window and letter run. Each read
// beat queues the count it should return. Each result beat is checked against
// the oldest queued count. The run covers every gram length and several mixes
// of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module letter_ngram_histogram_core_tb;

    localparam int GRAM_MAX = 3;
    localparam int WIN_BITS = lnh_pkg::LETTER_BITS * GRAM_MAX;

    // The package names three of the four mode codes. The fourth code does nothing.
    localparam logic [lnh_pkg::MODE_BITS-1:0] MODE_NOP = 2'd3;

    localparam int PHASE_ITEMS   = 100;
    localparam int LONG_HOLD     = 400;
    // Draining waits until the core is back in idle, clearing sweep included.
    // A settling gap of quiet cycles then separates the phases.
    localparam int SETTLE_CYCLES = 10;
    // Each clear, and the reset, sweeps 32768 counters. The limit leaves room for
    // a handful of sweeps plus 600 beats with stalls.
    localparam int TIMEOUT_NS    = 30_000_000;

    typedef struct packed {
        logic [lnh_pkg::MODE_BITS-1:0]  mode;
        logic [lnh_pkg::BYTE_BITS-1:0]  text_byte;
        logic [lnh_pkg::INDEX_BITS-1:0] gram_index;
    } text_cmd_t;

    logic                           aclk         = 1'b0;
    logic                           aresetn      = 1'b0;
    logic                           s_valid      = 1'b0;
    logic                           s_ready;
    logic [lnh_pkg::MODE_BITS-1:0]  s_mode       = lnh_pkg::MODE_FEED;
    logic [lnh_pkg::BYTE_BITS-1:0]  s_text_byte  = '0;
    logic [lnh_pkg::INDEX_BITS-1:0] s_gram_index = '0;
    logic                           m_valid;
    logic                           m_ready      = 1'b0;
    logic [lnh_pkg::OUT_BITS-1:0]   m_gram_count;
    logic                           cfg_wr_en    = 1'b0;
    logic [lnh_pkg::GLEN_BITS-1:0]  cfg_wr_data  = lnh_pkg::GLEN_RESET;

    // The initial block fills this queue. The driver empties it one beat at a time.
    text_cmd_t pending_cmds [$];
    text_cmd_t drive_cmd;

    // Shadow state of the core, kept only by the monitor.
    bit [lnh_pkg::OUT_BITS-1:0]     gram_tally [bit [WIN_BITS-1:0]];
    logic [WIN_BITS-1:0]            letter_shift  = '0;
    int unsigned                    letter_streak = 0;
    logic [lnh_pkg::GLEN_BITS-1:0]  gram_len_q    = lnh_pkg::GLEN_RESET;
    logic [lnh_pkg::OUT_BITS-1:0]   counts_due [$];
    logic [lnh_pkg::OUT_BITS-1:0]   count_head;

    // Traffic shaping. The initial block writes the percentages and hold requests,
    // which the driver and the receiver read. The receiver keeps the hold counts.
    int unsigned idle_pct      = 0;
    int unsigned stall_pct     = 0;
    int unsigned hold_requests = 0;
    int unsigned holds_served  = 0;
    int unsigned hold_left     = 0;

    // The stimulus side tracks the letters it sends so that most reads hit
    // counters that are likely to be nonzero.
    logic [WIN_BITS-1:0]   recent_letters = '0;

    int unsigned mismatches = 0;

    letter_ngram_histogram_core u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_mode       (s_mode),
        .s_text_byte  (s_text_byte),
        .s_gram_index (s_gram_index),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_gram_count (m_gram_count),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Applies one accepted beat to the shadow state. For a read, it queues the
    // count that the core should return.
    function automatic void apply_command(input text_cmd_t c);
        logic [lnh_pkg::BYTE_BITS-1:0] code;
        int unsigned                   span;
        bit [WIN_BITS-1:0]             key;
        case (c.mode)
            lnh_pkg::MODE_FEED: begin
                if (c.text_byte < lnh_pkg::LETTER_FIRST
                        || c.text_byte > lnh_pkg::LETTER_LAST) begin
                    // Any byte other than a letter ends the run. The window
                    // keeps its old letters.
                    letter_streak = 0;
                end else begin
                    code = c.text_byte - lnh_pkg::LETTER_FIRST;
                    letter_shift = {letter_shift[WIN_BITS-lnh_pkg::LETTER_BITS-1:0],
                                    code[lnh_pkg::LETTER_BITS-1:0]};
                    if (letter_streak < GRAM_MAX) letter_streak++;
                    span = (gram_len_q > GRAM_MAX) ? GRAM_MAX : gram_len_q;
                    // With a gram length of zero, no gram is counted.
                    if (span != 0 && letter_streak >= span) begin
                        key = letter_shift
                            & WIN_BITS'((1 << (lnh_pkg::LETTER_BITS * span)) - 1);
                        if (!gram_tally.exists(key)) gram_tally[key] = '0;
                        // A full counter stays at its maximum.
                        if (gram_tally[key] != '1) gram_tally[key]++;
                    end
                end
            end
            lnh_pkg::MODE_READ: begin
                key = c.gram_index[WIN_BITS-1:0];
                counts_due.push_back(gram_tally.exists(key) ? gram_tally[key] : '0);
            end
            lnh_pkg::MODE_CLEAR: begin
                gram_tally.delete();
                letter_shift  = '0;
                letter_streak = 0;
            end
            default: ;
        endcase
    endfunction

    task automatic note_error(input string what,
                              input logic [lnh_pkg::OUT_BITS-1:0] exp_val,
                              input logic [lnh_pkg::OUT_BITS-1:0] got_val);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t ns: %s: expected %0d, got %0d", $time, what, exp_val, got_val);
    endtask

    // Monitor. At each edge it samples the configuration write, the accepted
    // input beat and the accepted result beat, in that order.
    always @(posedge aclk) begin
        if (!aresetn) begin
            gram_tally.delete();
            letter_shift  = '0;
            letter_streak = 0;
            gram_len_q    = lnh_pkg::GLEN_RESET;
            counts_due.delete();
        end else begin
            if (cfg_wr_en) gram_len_q = cfg_wr_data;
            if (s_valid && s_ready) apply_command({s_mode, s_text_byte, s_gram_index});
            if (m_valid && m_ready) begin
                if (counts_due.size() == 0) begin
                    note_error("result beat with no read waiting", '0, m_gram_count);
                end else begin
                    count_head = counts_due.pop_front();
                    if (m_gram_count !== count_head)
                        note_error("gram_count", count_head, m_gram_count);
                end
            end
        end
    end

    // Driver. When the current beat has been taken, or no beat is offered, it
    // offers the next pending beat, unless a random gap is drawn.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (pending_cmds.size() != 0 && $urandom_range(99) >= idle_pct) begin
                drive_cmd = pending_cmds.pop_front();
                s_valid      <= 1'b1;
                s_mode       <= drive_cmd.mode;
                s_text_byte  <= drive_cmd.text_byte;
                s_gram_index <= drive_cmd.gram_index;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver. It stalls at random. When asked, it also holds m_ready low for
    // a long stretch that it counts itself.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (holds_served != hold_requests) begin
                holds_served = hold_requests;
                hold_left    = LONG_HOLD;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    task automatic queue_cmd(input logic [lnh_pkg::MODE_BITS-1:0] mode,
                             input logic [lnh_pkg::BYTE_BITS-1:0] text_byte,
                             input logic [lnh_pkg::INDEX_BITS-1:0] gram_index);
        pending_cmds.push_back({mode, text_byte, gram_index});
    endtask

    // Random beat. Most beats are letters from a small alphabet and reads of
    // grams that were just sent, so the counters grow. The rest are random
    // bytes, random reads, no-ops and a rare clear.
    function automatic text_cmd_t random_cmd();
        text_cmd_t                     c;
        int unsigned                   pick;
        int unsigned                   span;
        logic [lnh_pkg::BYTE_BITS-1:0] code;
        c.mode       = lnh_pkg::MODE_FEED;
        c.text_byte  = lnh_pkg::BYTE_BITS'($urandom);
        c.gram_index = lnh_pkg::INDEX_BITS'($urandom);
        pick = $urandom_range(999);
        if (pick < 4) begin
            c.mode = lnh_pkg::MODE_CLEAR;
        end else if (pick < 560) begin
            code = lnh_pkg::BYTE_BITS'(($urandom_range(3) != 0) ? $urandom_range(3)
                                                                : $urandom_range(25));
            c.text_byte    = lnh_pkg::LETTER_FIRST + code;
            recent_letters = {recent_letters[WIN_BITS-lnh_pkg::LETTER_BITS-1:0],
                              code[lnh_pkg::LETTER_BITS-1:0]};
        end else if (pick < 660) begin
            // Leave the random byte as it is. This is noise that tests the
            // letter range check.
        end else if (pick < 940) begin
            c.mode = lnh_pkg::MODE_READ;
            if ($urandom_range(2) != 0) begin
                span = $urandom_range(GRAM_MAX, 1);
                c.gram_index = lnh_pkg::INDEX_BITS'(recent_letters
                    & WIN_BITS'((1 << (lnh_pkg::LETTER_BITS * span)) - 1));
            end
        end else begin
            c.mode = MODE_NOP;
        end
        return c;
    endfunction

    // No-op beats do not count toward the number of beats asked for.
    task automatic queue_random(input int unsigned count);
        text_cmd_t   c;
        int unsigned done;
        done = 0;
        while (done < count) begin
            c = random_cmd();
            pending_cmds.push_back(c);
            if (c.mode != MODE_NOP) done++;
        end
    endtask

    // The initial block looks at the queues on falling edges, so that it never
    // races the clocked processes. The core counts as drained only once it is
    // idle again, so a clearing sweep is waited out as well.
    task automatic wait_drained();
        @(negedge aclk);
        while (pending_cmds.size() != 0 || s_valid || counts_due.size() != 0
               || !s_ready)
            @(negedge aclk);
    endtask

    task automatic write_gram_length(input logic [lnh_pkg::GLEN_BITS-1:0] glen);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= glen;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        @(negedge aclk);
    endtask

    // One phase sets the gram length and the traffic mix. It sends half of its
    // beats, pauses until every count is back, and then sends the rest.
    task automatic run_phase(input logic [lnh_pkg::GLEN_BITS-1:0] glen,
                             input int unsigned idle,
                             input int unsigned stall, input bit long_hold);
        write_gram_length(glen);
        idle_pct  = idle;
        stall_pct = stall;
        if (long_hold) hold_requests++;
        queue_random(PHASE_ITEMS / 2);
        wait_drained();
        queue_random(PHASE_ITEMS / 2);
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed beats, at the reset gram length of two.
        queue_cmd(lnh_pkg::MODE_READ, 8'h00, '0);                // nothing counted yet
        queue_cmd(lnh_pkg::MODE_FEED, lnh_pkg::LETTER_FIRST, '0);
        queue_cmd(lnh_pkg::MODE_FEED, lnh_pkg::LETTER_LAST, '1);
        queue_cmd(lnh_pkg::MODE_FEED, lnh_pkg::LETTER_FIRST, '0);
        // These bytes lie just outside the letter range or at the ends of the
        // byte range. Each one ends the run.
        queue_cmd(lnh_pkg::MODE_FEED, lnh_pkg::LETTER_FIRST - 8'd1, '0);
        queue_cmd(lnh_pkg::MODE_FEED, lnh_pkg::LETTER_LAST + 8'd1, '0);
        queue_cmd(lnh_pkg::MODE_FEED, 8'h00, '0);
        queue_cmd(lnh_pkg::MODE_FEED, 8'hff, '1);
        // A single letter after the break counts nothing. The second completes a gram.
        queue_cmd(lnh_pkg::MODE_FEED, lnh_pkg::LETTER_FIRST, '0);
        queue_cmd(lnh_pkg::MODE_FEED, lnh_pkg::LETTER_FIRST, '0);
        queue_cmd(lnh_pkg::MODE_READ, 8'hff, 15'd0);
        queue_cmd(lnh_pkg::MODE_READ, 8'h00, 15'd25);
        queue_cmd(lnh_pkg::MODE_READ, 8'h00, 15'd800);
        queue_cmd(lnh_pkg::MODE_READ, 8'h00, 15'h7fff);
        // A no-op beat with every field at ones must change nothing.
        queue_cmd(MODE_NOP, 8'hff, '1);
        queue_cmd(lnh_pkg::MODE_READ, 8'h00, 15'd25);
        queue_cmd(lnh_pkg::MODE_CLEAR, 8'hff, '1);
        queue_cmd(lnh_pkg::MODE_READ, 8'h00, 15'd25);
        // A long run of one letter: the run saturates and the same pair is
        // counted again on every letter after the first.
        repeat (4) queue_cmd(lnh_pkg::MODE_FEED, lnh_pkg::LETTER_LAST, '0);
        queue_cmd(lnh_pkg::MODE_READ, 8'h00, 15'd825);
        queue_cmd(lnh_pkg::MODE_READ, 8'h00, 15'd25);
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge aclk);

        // Random phases. The first one starts with a long receiver hold while
        // the sender keeps going, so the core fills up and stalls its input.
        run_phase(2'd1, 0, 0, 1'b1);
        run_phase(2'd3, 76, 0, 1'b0);
        run_phase(2'd0, 0, 76, 1'b0);
        run_phase(2'd3, 24, 24, 1'b0);
        run_phase(lnh_pkg::GLEN_RESET, 0, 0, 1'b0);
        run_phase(2'd1, 24, 24, 1'b0);

        if (mismatches == 0 && counts_due.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Mismatches found");
        $finish;
    end

endmodule
